@@ rtl/core/ppmfd_pkg.sv @@
// Package for the PPM frame decoder: sizing constants, register indexes,
// payload structs. No dependencies.
package ppmfd_pkg;

  localparam int unsigned NUM_CHANNELS = 6;
  localparam int unsigned TIME_BITS    = 16;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SYNC_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMER_WRAP     = 1'd1;

  localparam logic [15:0] SYNC_THRESHOLD_RST = 16'd2100;
  localparam logic [15:0] TIMER_WRAP_RST     = 16'd60000;

  typedef struct packed {
    logic        req_type;
    logic [15:0] edge_time;
  } ppm_in_t;

  typedef struct packed {
    logic        width_valid;
    logic [2:0]  channel;
    logic [15:0] pulse_width;
    logic        sync_seen;
    logic [3:0]  frame_channels;
    logic        overflow;
    logic [15:0] width_min;
    logic [15:0] width_max;
  } ppm_out_t;

endpackage

@@ rtl/core/ppm_frame_decoder.sv @@
// PPM frame decoder top level: edge timing, channel sequencing and the
// per-channel min/max statistics memory. Depends on ppmfd_pkg.
//
//   channel  | signals                           | direction
//   ---------+-----------------------------------+----------
//   input    | in_valid_i/in_ready_o/in_data_i   | in, one word per edge or clear
//   output   | out_valid_o/out_ready_i/out_data_o| out, one word per input word
//   config   | cfg_we_i/cfg_idx_i/cfg_wdata_i    | in, write only
//
// One word per cycle sustained while the output is not stalled. The accepting
// edge does the edge timing and the read of the statistics entry; the edge that
// advances stage 1 does the min/max update, write-back and loads the output
// register. Consecutive stores always hit different channels, so the read never
// needs the write in flight. Clear drops all per-entry valid bits at once; no
// clearing pass. Stalls on the output hold stage 1 and the input.
module ppm_frame_decoder (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  ppmfd_pkg::ppm_in_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output ppmfd_pkg::ppm_out_t                 out_data_o,
  input  logic                                cfg_we_i,
  input  logic [ppmfd_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ppmfd_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);
  import ppmfd_pkg::*;

  localparam int unsigned SUM_W  = ((TIME_BITS > 16) ? TIME_BITS : 16) + 1;
  localparam int unsigned ADDR_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [SUM_W-1:0] TIME_MASK = (SUM_W'(1) << TIME_BITS) - SUM_W'(1);

  typedef enum logic [1:0] {
    K_NONE,
    K_SYNC,
    K_STORE,
    K_OVERFLOW
  } kind_e;

  typedef struct packed {
    logic [15:0] wmin;
    logic [15:0] wmax;
  } stat_t;

  // configuration
  logic [15:0] sync_thr_q, timer_wrap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_thr_q   <= SYNC_THRESHOLD_RST;
      timer_wrap_q <= TIMER_WRAP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SYNC_THRESHOLD: sync_thr_q   <= cfg_wdata_i;
        REG_TIMER_WRAP:     timer_wrap_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // stage 0: edge timing and channel sequencing
  logic [TIME_BITS-1:0] last_edge_q, last_edge_d;
  logic                 have_edge_q, have_edge_d;
  logic [3:0]           chan_index_q, chan_index_d;
  logic [3:0]           chan_count_q, chan_count_d;

  logic              s1_valid_q, s1_adv, in_acc;
  kind_e             s1_kind_q, kind_d;
  logic [15:0]       s1_width_q, width_d;
  logic [ADDR_W-1:0] s1_addr_q;
  logic [3:0]        s1_fc_q;
  logic              s1_ent_vld_q;

  logic [SUM_W-1:0] now_ext, last_ext, delta_ext;

  assign s1_adv     = !out_valid_o || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    now_ext  = SUM_W'(in_data_i.edge_time) & TIME_MASK;
    last_ext = SUM_W'(last_edge_q);
    if (now_ext > last_ext) begin
      delta_ext = now_ext - last_ext;
    end else begin
      delta_ext = (now_ext + SUM_W'(timer_wrap_q) - last_ext) & TIME_MASK;
    end
    // saturate to 16 bits
    width_d = (|delta_ext[SUM_W-1:16]) ? 16'hFFFF : delta_ext[15:0];

    last_edge_d  = last_edge_q;
    have_edge_d  = have_edge_q;
    chan_index_d = chan_index_q;
    chan_count_d = chan_count_q;
    kind_d       = K_NONE;
    if (!in_data_i.req_type) begin
      have_edge_d = 1'b1;
      last_edge_d = now_ext[TIME_BITS-1:0];
      if (have_edge_q) begin
        if (delta_ext > SUM_W'(sync_thr_q)) begin
          kind_d       = K_SYNC;
          chan_count_d = chan_index_q;
          chan_index_d = 4'd0;
        end else if (chan_index_q < 4'(NUM_CHANNELS)) begin
          kind_d       = K_STORE;
          chan_index_d = chan_index_q + 4'd1;
        end else begin
          kind_d = K_OVERFLOW;
        end
      end
    end
  end

  // statistics memory, valid bits stand in for the all-ones / zero reset
  stat_t                   stat_mem [NUM_CHANNELS];
  stat_t                   rd_q;
  logic [NUM_CHANNELS-1:0] ent_vld_q, ent_vld_d;
  logic                    wr_en;
  stat_t                   wr_data;

  always_ff @(posedge clk_i) begin
    if (wr_en) stat_mem[s1_addr_q] <= wr_data;
    if (in_acc) rd_q <= stat_mem[chan_index_q[ADDR_W-1:0]];
  end

  always_comb begin
    ent_vld_d = ent_vld_q;
    if (wr_en) ent_vld_d[s1_addr_q] = 1'b1;
    // a clear is younger than the store in stage 1, so it wins
    if (in_acc && in_data_i.req_type) ent_vld_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= '0;
    end else begin
      ent_vld_q <= ent_vld_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_edge_q  <= '0;
      have_edge_q  <= 1'b0;
      chan_index_q <= 4'd0;
      chan_count_q <= 4'd0;
      s1_valid_q   <= 1'b0;
    end else begin
      if (in_acc) begin
        last_edge_q  <= last_edge_d;
        have_edge_q  <= have_edge_d;
        chan_index_q <= chan_index_d;
        chan_count_q <= chan_count_d;
      end
      if (in_ready_o) s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_kind_q    <= kind_d;
      s1_width_q   <= width_d;
      s1_addr_q    <= chan_index_q[ADDR_W-1:0];
      s1_fc_q      <= chan_count_d;
      s1_ent_vld_q <= ent_vld_q[chan_index_q[ADDR_W-1:0]];
    end
  end

  // stage 1: min/max update, write-back, output word
  stat_t    old_stat;
  ppm_out_t res_d;
  ppm_out_t out_q;
  logic     out_valid_q;

  always_comb begin
    old_stat = s1_ent_vld_q ? rd_q : stat_t'{wmin: 16'hFFFF, wmax: 16'h0000};
    wr_data.wmin = (s1_width_q < old_stat.wmin) ? s1_width_q : old_stat.wmin;
    wr_data.wmax = (s1_width_q > old_stat.wmax) ? s1_width_q : old_stat.wmax;
    wr_en = s1_valid_q && s1_adv && (s1_kind_q == K_STORE);

    res_d = '0;
    res_d.frame_channels = s1_fc_q;
    unique case (s1_kind_q)
      K_NONE: ;
      K_SYNC: begin
        res_d.pulse_width = s1_width_q;
        res_d.sync_seen   = 1'b1;
      end
      K_STORE: begin
        res_d.width_valid = 1'b1;
        res_d.channel     = 3'(s1_addr_q);
        res_d.pulse_width = s1_width_q;
        res_d.width_min   = wr_data.wmin;
        res_d.width_max   = wr_data.wmax;
      end
      K_OVERFLOW: begin
        res_d.pulse_width = s1_width_q;
        res_d.overflow    = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) out_q <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ rtl/core/ppmfd_chk.sv @@
// Port-level checks for the PPM frame decoder, bound to the top level.
// Depends on ppmfd_pkg and ppm_frame_decoder.
module ppmfd_chk (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input ppmfd_pkg::ppm_in_t               in_data_i,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input ppmfd_pkg::ppm_out_t              out_data_o
);
  import ppmfd_pkg::*;

  // an offered input word holds until taken
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("input word changed before acceptance");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word changed under stall");

  // a store excludes sync and overflow
  a_store_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.width_valid |->
      !out_data_o.sync_seen && !out_data_o.overflow)
    else $error("store flagged as sync or overflow");

  // stats after an update bracket the stored width
  a_stat_bracket: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.width_valid |->
      out_data_o.width_min <= out_data_o.pulse_width &&
      out_data_o.width_max >= out_data_o.pulse_width)
    else $error("min/max do not bracket width");

  // no store: channel and stats read zero
  a_nostore_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.width_valid |->
      out_data_o.channel == 3'd0 && out_data_o.width_min == 16'd0 &&
      out_data_o.width_max == 16'd0)
    else $error("non-store word carries channel data");

endmodule

bind ppm_frame_decoder ppmfd_chk u_ppmfd_chk (.*);
